[design/mrus_pkg.sv]
// Shared types and constants of the mono row upscaler.
`timescale 1ns / 1ps

package mrus_pkg;

    // Default geometry of the source
    localparam int SRC_ROW_BYTES_DEF = 50;
    localparam int SRC_ROWS_DEF      = 240;
    localparam int SRC_WIDTH_DEF     = 400;

    // Output geometry
    localparam int SCALE_W_800  = 800;
    localparam int SCALE_W_640  = 640;
    localparam int SCALE_H_640  = 384;
    localparam int FB_H_HALF    = 240;
    localparam int FB_H_FULL    = 480;
    localparam int ROW_BYTES_800 = SCALE_W_800 / 8;
    localparam int ROW_BYTES_640 = SCALE_W_640 / 8;
    localparam int Y_OFF_640     = (FB_H_FULL - SCALE_H_640) / 2;

    // Widths
    localparam int ROW_W    = 8;
    localparam int IDX_W    = 6;
    localparam int PIX_W    = 8;
    localparam int ADDR_W   = 16;
    localparam int COL_W    = 7;
    localparam int RBYTES_W = 7;
    localparam int HGT_W    = 9;
    localparam int PROD_W   = ROW_W + HGT_W;
    localparam int YOFF_W   = 6;

    localparam logic [COL_W-1:0] COL_MAX = {COL_W{1'b1}};

    // Queue between the front and the back
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_MODE_640      = 2'd0,
        CFG_SCANOUT_HALF  = 2'd1,
        CFG_BIT_REVERSE   = 2'd2,
        CFG_INVERT_PIXELS = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [ROW_W-1:0] source_row;
        logic [IDX_W-1:0] byte_index;
        logic [PIX_W-1:0] pixel_byte;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] fb_address;
        logic [PIX_W-1:0]  fb_data;
        logic              last_of_item;
    } out_item_t;

    // One classified source byte: up to two columns on up to two rows
    typedef struct packed {
        logic [ADDR_W-1:0]   base;
        logic [RBYTES_W-1:0] row_bytes;
        logic                two_rows;
        logic                two_cols;
        logic [PIX_W-1:0]    data0;
        logic [PIX_W-1:0]    data1;
        logic [COL_W-1:0]    col0;
        logic [COL_W-1:0]    col1;
    } wr_entry_t;

endpackage

[design/mrus_front.sv]
// Front end: configuration, byte expansion, carry state and row mapping.
`timescale 1ns / 1ps

module mrus_front #(
    parameter int SRC_ROW_BYTES = mrus_pkg::SRC_ROW_BYTES_DEF,
    parameter int SRC_ROWS      = mrus_pkg::SRC_ROWS_DEF,
    parameter int SRC_WIDTH     = mrus_pkg::SRC_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  mrus_pkg::in_item_t  in_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  mrus_pkg::cfg_reg_t  cfg_index,
    input  logic                cfg_data,
    output logic                push,
    output mrus_pkg::wr_entry_t push_entry,
    input  logic                push_ready
);

    localparam logic WIDE_2X = (SRC_WIDTH * 2 == mrus_pkg::SCALE_W_800);
    localparam int   COL_W   = mrus_pkg::COL_W;
    localparam int   PIX_W   = mrus_pkg::PIX_W;
    localparam int   HGT_W   = mrus_pkg::HGT_W;
    localparam int   PROD_W  = mrus_pkg::PROD_W;
    localparam int   RB_W    = mrus_pkg::RBYTES_W;
    localparam int   YOFF_W  = mrus_pkg::YOFF_W;
    localparam int   WIN_W   = 15;

    // Reciprocal of the source height, exact for every product below 2**PROD_W
    localparam int   DIV_S   = PROD_W + $clog2(SRC_ROWS);
    localparam int   RECIP_W = PROD_W + 1;
    localparam int   MUL_W   = PROD_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((1 << DIV_S) + SRC_ROWS - 1) / SRC_ROWS);

    // Reverse the bit order of a byte
    function automatic logic [7:0] reverse8(input logic [7:0] n);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = n[7 - i];
        end
        return r;
    endfunction

    // Double every pixel
    function automatic logic [15:0] widen2x(input logic [7:0] v);
        logic [15:0] r;
        for (int k = 0; k < 8; k++) begin
            r[2*k]     = v[k];
            r[2*k + 1] = v[k];
        end
        return r;
    endfunction

    // Stretch five pixels to eight
    function automatic logic [7:0] widen5(input logic [4:0] v);
        logic [7:0] r;
        for (int k = 0; k < 8; k++) begin
            r[k] = v[(k * 5) >> 3];
        end
        return r;
    endfunction

    function automatic logic [COL_W-1:0] sat_inc(input logic [COL_W-1:0] c);
        return (c == mrus_pkg::COL_MAX) ? c : c + 1'b1;
    endfunction

    // Configuration registers
    logic mode_640_reg;
    logic scanout_half_reg;
    logic bit_reverse_reg;
    logic invert_pixels_reg;

    // Running state of the row
    logic [3:0]       carry_bits_reg,  carry_bits_next;
    logic [2:0]       carry_count_reg, carry_count_next;
    logic [COL_W-1:0] out_column_reg,  out_column_next;

    // Stage one: expanded byte and row products
    logic                  s1_valid_reg;
    logic [PROD_W-1:0]     s1_p0_reg, s1_p1_reg;
    logic [HGT_W-1:0]      s1_scale_h_reg;
    logic [RB_W-1:0]       s1_row_bytes_reg;
    logic [YOFF_W-1:0]     s1_y_off_reg;
    logic [PIX_W-1:0]      s1_data0_reg, s1_data1_reg;
    logic [COL_W-1:0]      s1_col0_reg, s1_col1_reg;
    logic                  s1_two_cols_reg;

    // Stage two: first output row
    logic                  s2_valid_reg;
    logic [HGT_W-1:0]      s2_y0_reg;
    logic                  s2_two_rows_reg;
    logic [RB_W-1:0]       s2_row_bytes_reg;
    logic [YOFF_W-1:0]     s2_y_off_reg;
    logic [PIX_W-1:0]      s2_data0_reg, s2_data1_reg;
    logic [COL_W-1:0]      s2_col0_reg, s2_col1_reg;
    logic                  s2_two_cols_reg;

    logic                  accept, drop, s1_adv, s2_adv, s1_load;
    logic [RB_W-1:0]       row_bytes;
    logic [HGT_W-1:0]      scale_h;
    logic [YOFF_W-1:0]     y_off;
    logic [3:0]            cb;
    logic [2:0]            cc;
    logic [COL_W-1:0]      oc, oc1;
    logic [7:0]            src, src_rev;
    logic [15:0]           w2;
    logic [WIN_W-1:0]      win, win_sh;
    logic [3:0]            cnt, cnt_left;
    logic                  nout2;
    logic [7:0]            c2_sum;
    logic [PIX_W-1:0]      data0, data1;
    logic [COL_W-1:0]      col0, col1;
    logic                  v0, v1;
    logic [PROD_W-1:0]     p0, p1;
    logic [MUL_W-1:0]      m0, m1;
    logic [PROD_W-1:0]     q0, q1;
    logic [HGT_W-1:0]      y0, y1;
    logic [HGT_W-1:0]      y_diff;
    logic [HGT_W:0]        y_sum;
    logic [PROD_W-1:0]     base_full;

    assign cfg_ready = 1'b1;

    // Write configuration
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mode_640_reg      <= 1'b0;
            scanout_half_reg  <= 1'b0;
            bit_reverse_reg   <= 1'b1;
            invert_pixels_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                mrus_pkg::CFG_MODE_640:      mode_640_reg      <= cfg_data;
                mrus_pkg::CFG_SCANOUT_HALF:  scanout_half_reg  <= cfg_data;
                mrus_pkg::CFG_BIT_REVERSE:   bit_reverse_reg   <= cfg_data;
                mrus_pkg::CFG_INVERT_PIXELS: invert_pixels_reg <= cfg_data;
            endcase
        end
    end

    // Pipeline handshake
    assign s2_adv   = !s2_valid_reg || push_ready;
    assign s1_adv   = !s1_valid_reg || s2_adv;
    assign in_stall = s1_valid_reg && !s1_adv;
    assign accept   = in_valid && !in_stall;

    // Mode geometry and drop check
    always_comb begin
        row_bytes = mode_640_reg ? RB_W'(mrus_pkg::ROW_BYTES_640)
                                 : RB_W'(mrus_pkg::ROW_BYTES_800);
        if (mode_640_reg) begin
            scale_h = HGT_W'(mrus_pkg::SCALE_H_640);
        end else if (scanout_half_reg) begin
            scale_h = HGT_W'(mrus_pkg::FB_H_HALF);
        end else begin
            scale_h = HGT_W'(mrus_pkg::FB_H_FULL);
        end
        y_off = mode_640_reg ? YOFF_W'(mrus_pkg::Y_OFF_640) : '0;
        drop  = ({1'b0, in_data.source_row} >= 9'(SRC_ROWS))
             || ({2'b00, in_data.byte_index} >= 8'(SRC_ROW_BYTES));
    end

    // Expand the byte and advance the carry state
    always_comb begin
        if (in_data.byte_index == '0) begin
            cb = '0;
            cc = '0;
            oc = '0;
        end else begin
            cb = carry_bits_reg;
            cc = carry_count_reg;
            oc = out_column_reg;
        end
        src_rev = bit_reverse_reg ? reverse8(in_data.pixel_byte) : in_data.pixel_byte;
        src     = invert_pixels_reg ? ~src_rev : src_rev;
        w2      = widen2x(src);
        win     = WIN_W'(cb) | (WIN_W'(src) << cc);
        cnt     = 4'(cc) + 4'd8;
        nout2   = (cnt >= 4'd10);
        win_sh  = nout2 ? (win >> 10) : (win >> 5);
        cnt_left = nout2 ? (cnt - 4'd10) : (cnt - 4'd5);
        oc1     = sat_inc(oc);
        c2_sum  = {1'b0, in_data.byte_index, 1'b0} + 8'd2;
        if (!mode_640_reg && WIDE_2X) begin
            data0            = w2[7:0];
            data1            = w2[15:8];
            col0             = {in_data.byte_index, 1'b0};
            col1             = {in_data.byte_index, 1'b1};
            v1               = (col1 < row_bytes);
            out_column_next  = (c2_sum > 8'(mrus_pkg::COL_MAX)) ? mrus_pkg::COL_MAX
                                                                 : c2_sum[COL_W-1:0];
            carry_bits_next  = cb;
            carry_count_next = cc;
        end else begin
            data0            = widen5(win[4:0]);
            data1            = widen5(win[9:5]);
            col0             = oc;
            col1             = oc1;
            v1               = nout2 && (col1 < row_bytes);
            out_column_next  = nout2 ? sat_inc(oc1) : oc1;
            carry_bits_next  = win_sh[3:0];
            carry_count_next = cnt_left[2:0];
        end
        v0 = (col0 < row_bytes);
        p0 = PROD_W'(in_data.source_row) * PROD_W'(scale_h);
        p1 = (PROD_W'(in_data.source_row) + 1'b1) * PROD_W'(scale_h);
    end

    assign s1_load = accept && !drop && v0;

    // Hold the running state across bytes of a row
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            carry_bits_reg  <= '0;
            carry_count_reg <= '0;
            out_column_reg  <= '0;
        end else if (accept && !drop) begin
            carry_bits_reg  <= carry_bits_next;
            carry_count_reg <= carry_count_next;
            out_column_reg  <= out_column_next;
        end
    end

    // Stage one registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            s1_valid_reg <= s1_load;
        end
    end

    always_ff @(posedge clk) begin
        if (s1_adv && s1_load) begin
            s1_p0_reg        <= p0;
            s1_p1_reg        <= p1;
            s1_scale_h_reg   <= scale_h;
            s1_row_bytes_reg <= row_bytes;
            s1_y_off_reg     <= y_off;
            s1_data0_reg     <= data0;
            s1_data1_reg     <= data1;
            s1_col0_reg      <= col0;
            s1_col1_reg      <= col1;
            s1_two_cols_reg  <= v1;
        end
    end

    // Map the source row to its output rows; divide by reciprocal multiply
    always_comb begin
        m0     = MUL_W'(s1_p0_reg) * MUL_W'(RECIP);
        m1     = MUL_W'(s1_p1_reg) * MUL_W'(RECIP);
        q0     = PROD_W'(m0 >> DIV_S);
        q1     = PROD_W'(m1 >> DIV_S);
        y0     = q0[HGT_W-1:0];
        y1     = (q1 > PROD_W'(s1_scale_h_reg)) ? s1_scale_h_reg : q1[HGT_W-1:0];
        y_diff = (y1 > y0) ? (y1 - y0) : '0;
    end

    // Stage two registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_adv) begin
            s2_valid_reg <= s1_valid_reg && (y_diff != '0);
        end
    end

    always_ff @(posedge clk) begin
        if (s2_adv && s1_valid_reg) begin
            s2_y0_reg        <= y0;
            s2_two_rows_reg  <= (y_diff >= HGT_W'(2));
            s2_row_bytes_reg <= s1_row_bytes_reg;
            s2_y_off_reg     <= s1_y_off_reg;
            s2_data0_reg     <= s1_data0_reg;
            s2_data1_reg     <= s1_data1_reg;
            s2_col0_reg      <= s1_col0_reg;
            s2_col1_reg      <= s1_col1_reg;
            s2_two_cols_reg  <= s1_two_cols_reg;
        end
    end

    // Row base address and queue entry
    always_comb begin
        y_sum     = (HGT_W+1)'(s2_y0_reg) + (HGT_W+1)'(s2_y_off_reg);
        base_full = PROD_W'(y_sum) * PROD_W'(s2_row_bytes_reg);
        push                 = s2_valid_reg;
        push_entry.base      = base_full[mrus_pkg::ADDR_W-1:0];
        push_entry.row_bytes = s2_row_bytes_reg;
        push_entry.two_rows  = s2_two_rows_reg;
        push_entry.two_cols  = s2_two_cols_reg;
        push_entry.data0     = s2_data0_reg;
        push_entry.data1     = s2_data1_reg;
        push_entry.col0      = s2_col0_reg;
        push_entry.col1      = s2_col1_reg;
    end

    // The row state moves only on a transfer
    a_state_on_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(out_column_reg) && $stable(carry_count_reg))
        else $error("row state changed without an input transfer");

endmodule

[design/mrus_queue.sv]
// Short queue of classified bytes between the front and the back.
`timescale 1ns / 1ps

module mrus_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mrus_pkg::wr_entry_t push_entry,
    output logic                push_ready,
    output logic                head_valid,
    output mrus_pkg::wr_entry_t head_entry,
    input  logic                pop
);

    localparam int DEPTH = mrus_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mrus_pkg::wr_entry_t entries_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                do_push, do_pop;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = entries_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    // Store entries
    always_ff @(posedge clk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count beyond depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from an empty queue");

endmodule

[design/mrus_back.sv]
// Back end: walks each queued byte over its rows and columns, one write a cycle unless stalled.
`timescale 1ns / 1ps

module mrus_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  mrus_pkg::wr_entry_t head_entry,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output mrus_pkg::out_item_t out_data
);

    localparam int ADDR_W = mrus_pkg::ADDR_W;

    logic                row_sel_reg, row_sel_next;
    logic                col_sel_reg, col_sel_next;
    logic                out_valid_reg;
    mrus_pkg::out_item_t out_data_reg;
    mrus_pkg::out_item_t slot;
    logic                load, slot_last;

    assign load      = head_valid && (!out_valid_reg || !out_stall);
    assign slot_last = (col_sel_reg == head_entry.two_cols)
                    && (row_sel_reg == head_entry.two_rows);
    assign pop       = load && slot_last;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Build the write for the current row and column
    always_comb begin
        slot.fb_address = head_entry.base
                        + (row_sel_reg ? ADDR_W'(head_entry.row_bytes) : '0)
                        + ADDR_W'(col_sel_reg ? head_entry.col1 : head_entry.col0);
        slot.fb_data      = col_sel_reg ? head_entry.data1 : head_entry.data0;
        slot.last_of_item = slot_last;
    end

    // Step columns first, then rows
    always_comb begin
        row_sel_next = row_sel_reg;
        col_sel_next = col_sel_reg;
        if (load) begin
            if (col_sel_reg != head_entry.two_cols) begin
                col_sel_next = 1'b1;
            end else begin
                col_sel_next = 1'b0;
                row_sel_next = (row_sel_reg != head_entry.two_rows);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            row_sel_reg   <= 1'b0;
            col_sel_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            row_sel_reg <= row_sel_next;
            col_sel_reg <= col_sel_next;
            if (load) begin
                out_valid_reg <= 1'b1;
            end else if (!out_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output register
    always_ff @(posedge clk) begin
        if (load) begin
            out_data_reg <= slot;
        end
    end

    // Writes of one byte follow without a gap
    a_no_gap_in_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_data_reg.last_of_item |=> out_valid_reg)
        else $error("gap inside the writes of one byte");

    // Slot counters stay inside the entry
    a_col_in_entry: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid && col_sel_reg |-> head_entry.two_cols)
        else $error("column slot past the entry");

    a_row_in_entry: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid && row_sel_reg |-> head_entry.two_rows)
        else $error("row slot past the entry");

endmodule

[design/mono_row_upscaler_top.sv]
// Top level of the mono row upscaler: 1bpp source rows to framebuffer writes.
`timescale 1ns / 1ps

// Source bytes arrive on the input channel (in_valid / in_stall), one transfer
// per byte with its row number and byte position; position 0 starts a row.
// Each byte becomes 0 to 4 framebuffer byte writes on the output channel
// (out_valid / out_stall): up to two columns on up to two output rows,
// last_of_item marks the final write of a byte. Rows past the source height
// and bytes past the row width produce no writes.
// Throughput: the front takes one byte per cycle through a two-stage pipe
// while in_stall is low; the back issues one write per cycle while out_stall
// is low, and a byte has 1 to 4 writes (4 in 800 wide full-height mode).
// The single write port of the back sets that rate.
// On its way out a byte passes the stage one and stage two registers, the
// queue and the output register of the back.
// A stalled output holds its write; the queue then fills and in_stall rises.
// Configuration writes (cfg_valid / cfg_ready) are taken at any cycle and
// belong between rows while the block is idle.
// Reset empties the pipe and queue, clears the carry state and loads the
// register defaults (bit reversal on, all else off).

module mono_row_upscaler_top #(
    parameter int SRC_ROW_BYTES = mrus_pkg::SRC_ROW_BYTES_DEF,
    parameter int SRC_ROWS      = mrus_pkg::SRC_ROWS_DEF,
    parameter int SRC_WIDTH     = mrus_pkg::SRC_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  mrus_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output mrus_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  mrus_pkg::cfg_reg_t  cfg_index,
    input  logic                cfg_data
);

    logic                push, push_ready, head_valid, pop;
    mrus_pkg::wr_entry_t push_entry, head_entry;

    mrus_front #(
        .SRC_ROW_BYTES (SRC_ROW_BYTES),
        .SRC_ROWS      (SRC_ROWS),
        .SRC_WIDTH     (SRC_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .push_entry (push_entry),
        .push_ready (push_ready)
    );

    mrus_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop)
    );

    mrus_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

[tb/mono_row_upscaler_top_tb.sv]
// Self-checking testbench of the mono row upscaler: random source rows against a predictor.
`timescale 1ns / 1ps

module mono_row_upscaler_top_tb;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    mrus_pkg::in_item_t   in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    mrus_pkg::out_item_t  out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    mrus_pkg::cfg_reg_t   cfg_index = mrus_pkg::CFG_MODE_640;
    logic                 cfg_data  = 1'b0;

    // Source bytes waiting for the driver
    mrus_pkg::in_item_t   src_bytes_q[$];
    int         queued_bytes   = 0;
    int         accepted_bytes = 0;

    // Predicted framebuffer writes, flat, plus the write count of each source byte
    mrus_pkg::out_item_t  fb_writes_q[$];
    int         writes_left_q[$];

    int         mismatch_count = 0;
    int         sender_idle_pct = 0;
    int         sink_stall_pct  = 0;

    // Register copy and scaler state of the predictor
    logic       cur_mode_640 = 1'b0;
    logic       cur_half     = 1'b0;
    logic       cur_reverse  = 1'b1;
    logic       cur_invert   = 1'b0;
    int         carry_bits_q = 0;
    int         carry_cnt_q  = 0;
    int         next_column  = 0;

    mono_row_upscaler_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("mono_row_upscaler_top_tb NOT OK");
        $finish;
    end

    // Work out the framebuffer writes of one accepted source byte
    function automatic void predict_writes(mrus_pkg::in_item_t it);
        logic [7:0] pix;
        logic [7:0] part [2];
        int         col [2];
        int         n_part, n_wr, row, idx, row_bytes, scale_h, fb_h, y_off;
        int         y0, y1, n_rows, win, cnt, addr;
        mrus_pkg::out_item_t wr;

        row = it.source_row;
        idx = it.byte_index;
        if (row >= mrus_pkg::SRC_ROWS_DEF || idx >= mrus_pkg::SRC_ROW_BYTES_DEF)
            return;

        if (cur_mode_640)
        begin
            row_bytes = mrus_pkg::ROW_BYTES_640;
            scale_h   = mrus_pkg::SCALE_H_640;
            fb_h      = mrus_pkg::FB_H_FULL;
        end
        else
        begin
            row_bytes = mrus_pkg::ROW_BYTES_800;
            fb_h      = cur_half ? mrus_pkg::FB_H_HALF : mrus_pkg::FB_H_FULL;
            scale_h   = fb_h;
        end
        y_off = (fb_h - scale_h) / 2;

        // A row start drops the carry and rewinds the column
        if (idx == 0)
        begin
            carry_bits_q = 0;
            carry_cnt_q  = 0;
            next_column  = 0;
        end

        pix = it.pixel_byte;
        if (cur_reverse)
            for (int k = 0; k < 8; k++)
                pix[k] = it.pixel_byte[7 - k];
        if (cur_invert)
            pix = ~pix;

        n_part = 0;
        if (!cur_mode_640)
        begin
            // Double every pixel: two output bytes per source byte
            for (int k = 0; k < 8; k++)
            begin
                part[k / 4][(k % 4) * 2]     = pix[k];
                part[k / 4][(k % 4) * 2 + 1] = pix[k];
            end
            col[0]      = idx * 2;
            col[1]      = idx * 2 + 1;
            n_part      = 2;
            next_column = idx * 2 + 2;
        end
        else
        begin
            // Five source bits per output byte, leftovers carry forward
            win = carry_bits_q | (int'(pix) << carry_cnt_q);
            cnt = carry_cnt_q + 8;
            while (cnt >= 5 && n_part < 2)
            begin
                for (int k = 0; k < 8; k++)
                    part[n_part][k] = win[(k * 5) >> 3];
                col[n_part] = next_column;
                n_part++;
                if (next_column < 127)
                    next_column++;
                win = win >> 5;
                cnt = cnt - 5;
            end
            carry_bits_q = win & 15;
            carry_cnt_q  = cnt & 7;
        end

        y0 = row * scale_h / mrus_pkg::SRC_ROWS_DEF;
        y1 = (row + 1) * scale_h / mrus_pkg::SRC_ROWS_DEF;
        if (y1 > scale_h)
            y1 = scale_h;
        n_rows = (y1 > y0) ? y1 - y0 : 0;
        if (n_rows > 2)
            n_rows = 2;

        // The image spans the full row in both modes, so no column offset
        n_wr = 0;
        for (int r = 0; r < n_rows; r++)
            for (int j = 0; j < n_part; j++)
                if (col[j] < row_bytes)
                begin
                    addr            = (y0 + r + y_off) * row_bytes + col[j];
                    wr.fb_address   = addr[mrus_pkg::ADDR_W-1:0];
                    wr.fb_data      = part[j];
                    wr.last_of_item = 1'b0;
                    fb_writes_q.push_back(wr);
                    n_wr++;
                end
        if (n_wr > 0)
            writes_left_q.push_back(n_wr);
    endfunction

    // Match one write against the writes of the oldest pending source byte
    function automatic void check_write(mrus_pkg::out_item_t got);
        mrus_pkg::out_item_t want;
        int        hit;

        if (writes_left_q.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("unexpected write: addr %0d data %02h last %0b",
                         got.fb_address, got.fb_data, got.last_of_item);
            return;
        end

        hit = -1;
        for (int i = 0; i < writes_left_q[0]; i++)
            if (hit < 0 && fb_writes_q[i].fb_address == got.fb_address)
                hit = i;
        if (hit < 0)
            hit = 0;

        want              = fb_writes_q[hit];
        want.last_of_item = (writes_left_q[0] == 1);
        if (got !== want)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display({"write mismatch: expected addr %0d data %02h last %0b, ",
                          "got addr %0d data %02h last %0b"},
                         want.fb_address, want.fb_data, want.last_of_item,
                         got.fb_address, got.fb_data, got.last_of_item);
        end

        fb_writes_q.delete(hit);
        writes_left_q[0] = writes_left_q[0] - 1;
        if (writes_left_q[0] == 0)
            void'(writes_left_q.pop_front());
    endfunction

    // Drive source bytes; hold the payload while stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || !in_stall)
        begin
            if (src_bytes_q.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                in_data  <= src_bytes_q.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Stall the write channel at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    // Check writes first, then predict for the byte that transfers on this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                check_write(out_data);
            if (in_valid && !in_stall)
            begin
                predict_writes(in_data);
                accepted_bytes++;
            end
        end
    end

    task automatic queue_byte(int row, int idx, int pix);
        mrus_pkg::in_item_t it;
        it.source_row = row[mrus_pkg::ROW_W-1:0];
        it.byte_index = idx[mrus_pkg::IDX_W-1:0];
        it.pixel_byte = pix[mrus_pkg::PIX_W-1:0];
        src_bytes_q.push_back(it);
        queued_bytes++;
    endtask

    // Wait for every byte to transfer and every write to arrive, then settle
    task automatic drain();
        do
            @(negedge clk);
        while (accepted_bytes != queued_bytes || writes_left_q.size() != 0);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_reg(mrus_pkg::cfg_reg_t idx, logic val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            mrus_pkg::CFG_MODE_640:      cur_mode_640 = val;
            mrus_pkg::CFG_SCANOUT_HALF:  cur_half     = val;
            mrus_pkg::CFG_BIT_REVERSE:   cur_reverse  = val;
            mrus_pkg::CFG_INVERT_PIXELS: cur_invert   = val;
            default:                     ;
        endcase
    endtask

    task automatic set_config(logic mode, logic half, logic rev, logic inv);
        write_reg(mrus_pkg::CFG_MODE_640, mode);
        write_reg(mrus_pkg::CFG_SCANOUT_HALF, half);
        write_reg(mrus_pkg::CFG_BIT_REVERSE, rev);
        write_reg(mrus_pkg::CFG_INVERT_PIXELS, inv);
        @(negedge clk);
    endtask

    function automatic int pick_row();
        int sel;
        sel = $urandom_range(7);
        if (sel == 0)
            return 0;
        if (sel == 1)
            return mrus_pkg::SRC_ROWS_DEF - 1;
        return $urandom_range(mrus_pkg::SRC_ROWS_DEF - 1);
    endfunction

    initial
    begin
        int counted, kind, row, len, start, idx;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset defaults: 800 wide, full height, bit reversal on
        queue_byte(0, 0, 8'h00);
        queue_byte(0, 1, 8'hFF);
        queue_byte(0, 2, 8'h80);
        queue_byte(0, 3, 8'h01);
        queue_byte(0, 49, 8'hA5);
        queue_byte(239, 0, 8'h5A);
        queue_byte(240, 0, 8'hFF);
        queue_byte(255, 3, 8'hFF);
        queue_byte(10, 50, 8'hFF);
        queue_byte(10, 63, 8'h00);
        drain();

        // Letterboxed 640 with half height set (ignored), inverted, no reversal
        set_config(1'b1, 1'b1, 1'b0, 1'b1);
        queue_byte(0, 0, 8'hF0);
        queue_byte(0, 1, 8'h0F);
        queue_byte(0, 2, 8'hFF);
        queue_byte(0, 3, 8'h00);
        queue_byte(239, 0, 8'hC3);
        queue_byte(239, 1, 8'h3C);
        queue_byte(239, 5, 8'h81);
        queue_byte(100, 49, 8'h7E);
        drain();

        // Every register combination once, idling pattern rotated over them
        for (int p = 0; p < 16; p++)
        begin
            set_config(p[0], p[1], p[2], p[3]);
            case ((p + p / 4) % 4)
                0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin sender_idle_pct = 49; sink_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  sink_stall_pct = 49; end
                default: begin sender_idle_pct = 27; sink_stall_pct = 27; end
            endcase

            counted = 0;
            while (counted < 12)
            begin
                kind = $urandom_range(99);
                if (kind < 70)
                begin
                    // Well-formed row segment from a row start
                    row = pick_row();
                    len = ($urandom_range(5) == 0) ? mrus_pkg::SRC_ROW_BYTES_DEF
                                                   : $urandom_range(1, 12);
                    for (int i = 0; i < len; i++)
                        queue_byte(row, i, $urandom_range(255));
                    counted += len;
                end
                else if (kind < 85)
                begin
                    // Continue without a row start: in 640 mode columns run past the width
                    row   = pick_row();
                    start = $urandom_range(1, mrus_pkg::SRC_ROW_BYTES_DEF - 1);
                    len   = $urandom_range(1, 60);
                    for (int i = 0; i < len; i++)
                        queue_byte(row, 1 + (start + i) % (mrus_pkg::SRC_ROW_BYTES_DEF - 1),
                                   $urandom_range(255));
                    counted += len;
                end
                else
                begin
                    // Noise over the whole field ranges
                    row = $urandom_range(255);
                    idx = $urandom_range(63);
                    queue_byte(row, idx, $urandom_range(255));
                    if (row < mrus_pkg::SRC_ROWS_DEF && idx < mrus_pkg::SRC_ROW_BYTES_DEF)
                        counted++;
                end
            end
            drain();
        end

        if (mismatch_count == 0)
            $display("mono_row_upscaler_top_tb OK");
        else
            $display("mono_row_upscaler_top_tb NOT OK");
        $finish;
    end

endmodule
